[design/bole_pkg.sv]
// ----------------------------------------------------------------------------
// bole_pkg
// Shared types, operation and status codes, and controller/datapath bundles
// for the bounded ordered list engine.
// ----------------------------------------------------------------------------
package bole_pkg;

    localparam int DATA_W    = 32;
    localparam int MODE_W    = 3;
    localparam int POS_W     = 6;
    localparam int STAT_W    = 2;
    localparam int LEN_OUT_W = 6;

    typedef logic        [MODE_W-1:0]    t_mode;
    typedef logic signed [DATA_W-1:0]    t_data;
    typedef logic        [POS_W-1:0]     t_pos;
    typedef logic        [STAT_W-1:0]    t_status;
    typedef logic        [LEN_OUT_W-1:0] t_len_out;

    // operation codes
    localparam t_mode MODE_INS_HEAD = 3'd0;
    localparam t_mode MODE_INS_TAIL = 3'd1;
    localparam t_mode MODE_INS_POS  = 3'd2;
    localparam t_mode MODE_REMOVE   = 3'd3;
    localparam t_mode MODE_DUMP     = 3'd4;

    // result status codes
    localparam t_status ST_DONE      = 2'd0;
    localparam t_status ST_NOT_FOUND = 2'd1;
    localparam t_status ST_FULL      = 2'd2;
    localparam t_status ST_INDEX     = 2'd3;

    typedef enum logic [1:0] {TGT_HEAD, TGT_TAIL, TGT_POS} t_tgt_sel;
    typedef enum logic [2:0] {IDX_HOLD, IDX_LEN, IDX_ZERO, IDX_INC, IDX_DEC} t_idx_op;
    typedef enum logic [1:0] {RD_IDX, RD_PREV, RD_NEXT} t_rd_sel;
    typedef enum logic [1:0] {LEN_HOLD, LEN_INC, LEN_DEC} t_len_op;
    typedef enum logic       {WD_VALUE, WD_READ} t_wd_sel;

    typedef struct packed {
        logic     load;
        logic     set_tgt;
        t_tgt_sel tgt_sel;
        t_idx_op  idx_op;
        logic     rd_en;
        t_rd_sel  rd_sel;
        logic     wr_en;
        t_wd_sel  wd_sel;
        t_len_op  len_op;
        logic     out_load;
        logic     out_elem;
        t_status  out_status;
    } t_cmd;

    typedef struct packed {
        t_mode mode;
        logic  full;
        logic  pos_bad;
        logic  len_zero;
        logic  at_tgt;
        logic  match;
        logic  idx_last;
        logic  out_free;
    } t_sts;

endpackage

[design/bole_if.sv]
// ----------------------------------------------------------------------------
// bole_in_if / bole_out_if
// Valid/ready channels carrying list operations in and list results out.
// ----------------------------------------------------------------------------
interface bole_in_if import bole_pkg::*; ();
    logic  valid;
    logic  ready;
    t_mode mode;
    t_data value;
    t_pos  position;

    modport source (output valid, mode, value, position, input ready);
    modport sink   (input valid, mode, value, position, output ready);
endinterface

interface bole_out_if import bole_pkg::*; ();
    logic     valid;
    logic     ready;
    t_status  status;
    t_data    element;
    logic     element_valid;
    logic     last;
    t_len_out list_length;

    modport source (output valid, status, element, element_valid, last, list_length,
                    input ready);
    modport sink   (input valid, status, element, element_valid, last, list_length,
                    output ready);
endinterface

[design/bole_ctrl.sv]
// ----------------------------------------------------------------------------
// bole_ctrl
// Operation sequencer: decodes each operation and steps the datapath through
// shifts, searches and dump reads one memory access at a time.
// ----------------------------------------------------------------------------
module bole_ctrl import bole_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DECODE   = 4'd1;
    localparam logic [3:0] S_INS_CHK  = 4'd2;
    localparam logic [3:0] S_INS_WR   = 4'd3;
    localparam logic [3:0] S_SCAN_RD  = 4'd4;
    localparam logic [3:0] S_SCAN_CMP = 4'd5;
    localparam logic [3:0] S_DEL_CHK  = 4'd6;
    localparam logic [3:0] S_DEL_WR   = 4'd7;
    localparam logic [3:0] S_DUMP_RD  = 4'd8;
    localparam logic [3:0] S_DUMP_OUT = 4'd9;
    localparam logic [3:0] S_EMIT     = 4'd10;

    logic [3:0] r_state, n_state;
    t_status    r_status, n_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= ST_DONE;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
        end
    end

    always_comb begin
        n_state          = r_state;
        n_status         = r_status;
        o_ready          = 1'b0;
        o_cmd            = '0;
        o_cmd.out_status = r_status;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_sts.mode) inside
                    MODE_INS_HEAD, MODE_INS_TAIL, MODE_INS_POS: begin
                        if (i_sts.full) begin
                            n_status = ST_FULL;
                            n_state  = S_EMIT;
                        end else if (i_sts.mode == MODE_INS_POS && i_sts.pos_bad) begin
                            n_status = ST_INDEX;
                            n_state  = S_EMIT;
                        end else begin
                            o_cmd.set_tgt = 1'b1;
                            if (i_sts.mode == MODE_INS_HEAD) begin
                                o_cmd.tgt_sel = TGT_HEAD;
                            end else if (i_sts.mode == MODE_INS_TAIL) begin
                                o_cmd.tgt_sel = TGT_TAIL;
                            end else begin
                                o_cmd.tgt_sel = TGT_POS;
                            end
                            // shift walks down from the tail to the target
                            o_cmd.idx_op = IDX_LEN;
                            n_state      = S_INS_CHK;
                        end
                    end
                    MODE_REMOVE: begin
                        if (i_sts.len_zero) begin
                            n_status = ST_NOT_FOUND;
                            n_state  = S_EMIT;
                        end else begin
                            o_cmd.idx_op = IDX_ZERO;
                            n_state      = S_SCAN_RD;
                        end
                    end
                    MODE_DUMP: begin
                        if (i_sts.len_zero) begin
                            n_status = ST_DONE;
                            n_state  = S_EMIT;
                        end else begin
                            o_cmd.idx_op = IDX_ZERO;
                            n_state      = S_DUMP_RD;
                        end
                    end
                    default: begin
                        n_status = ST_DONE;
                        n_state  = S_EMIT;
                    end
                endcase
            end
            S_INS_CHK: begin
                if (i_sts.at_tgt) begin
                    o_cmd.wr_en  = 1'b1;
                    o_cmd.wd_sel = WD_VALUE;
                    o_cmd.len_op = LEN_INC;
                    n_status     = ST_DONE;
                    n_state      = S_EMIT;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_PREV;
                    n_state      = S_INS_WR;
                end
            end
            S_INS_WR: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wd_sel = WD_READ;
                o_cmd.idx_op = IDX_DEC;
                n_state      = S_INS_CHK;
            end
            S_SCAN_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_IDX;
                n_state      = S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                if (i_sts.match) begin
                    n_state = S_DEL_CHK;
                end else if (i_sts.idx_last) begin
                    n_status = ST_NOT_FOUND;
                    n_state  = S_EMIT;
                end else begin
                    o_cmd.idx_op = IDX_INC;
                    n_state      = S_SCAN_RD;
                end
            end
            S_DEL_CHK: begin
                if (i_sts.idx_last) begin
                    o_cmd.len_op = LEN_DEC;
                    n_status     = ST_DONE;
                    n_state      = S_EMIT;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_NEXT;
                    n_state      = S_DEL_WR;
                end
            end
            S_DEL_WR: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wd_sel = WD_READ;
                o_cmd.idx_op = IDX_INC;
                n_state      = S_DEL_CHK;
            end
            S_DUMP_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_IDX;
                n_state      = S_DUMP_OUT;
            end
            S_DUMP_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_elem = 1'b1;
                    o_cmd.idx_op   = IDX_INC;
                    n_state        = i_sts.idx_last ? S_IDLE : S_DUMP_RD;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[design/bole_dp.sv]
// ----------------------------------------------------------------------------
// bole_dp
// List datapath: entry memory with one write and one registered read port,
// length and walk index, operand capture and the result register.
// ----------------------------------------------------------------------------
module bole_dp import bole_pkg::*; #(
    parameter int CAPACITY = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cmd     i_cmd,
    output t_sts     o_sts,
    input  t_mode    i_mode,
    input  t_data    i_value,
    input  t_pos     i_position,
    output logic     o_valid,
    input  logic     i_ready,
    output t_status  o_status,
    output t_data    o_element,
    output logic     o_element_valid,
    output logic     o_last,
    output t_len_out o_list_length
);

    localparam int LW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);

    t_mode           r_mode;
    t_data           r_value;
    t_pos            r_pos;
    logic [LW-1:0]   r_len, n_len;
    logic [LW-1:0]   r_idx, n_idx;
    logic [LW-1:0]   r_tgt, n_tgt;
    t_data           r_rdata;
    t_data           r_mem [CAPACITY];

    logic            r_ovalid;
    t_status         r_ostatus;
    t_data           r_oelem;
    logic            r_oevalid;
    logic            r_olast;
    t_len_out        r_olen;

    logic [LW-1:0]   idx_prev, idx_next;
    logic [AW-1:0]   rd_addr;
    t_data           wdata;

    assign idx_prev = r_idx - LW'(1);
    assign idx_next = r_idx + LW'(1);

    always_comb begin
        case (i_cmd.rd_sel)
            RD_PREV: rd_addr = idx_prev[AW-1:0];
            RD_NEXT: rd_addr = idx_next[AW-1:0];
            default: rd_addr = r_idx[AW-1:0];
        endcase
        wdata = (i_cmd.wd_sel == WD_READ) ? r_rdata : r_value;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[r_idx[AW-1:0]] <= wdata;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_comb begin
        case (i_cmd.idx_op)
            IDX_LEN:  n_idx = r_len;
            IDX_ZERO: n_idx = '0;
            IDX_INC:  n_idx = idx_next;
            IDX_DEC:  n_idx = idx_prev;
            default:  n_idx = r_idx;
        endcase
        case (i_cmd.len_op)
            LEN_INC: n_len = r_len + LW'(1);
            LEN_DEC: n_len = r_len - LW'(1);
            default: n_len = r_len;
        endcase
        case (i_cmd.tgt_sel)
            TGT_TAIL: n_tgt = r_len;
            TGT_POS:  n_tgt = LW'(r_pos);
            default:  n_tgt = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_len <= n_len;
            if (i_cmd.out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (i_cmd.load) begin
            r_mode  <= i_mode;
            r_value <= i_value;
            r_pos   <= i_position;
        end
        if (i_cmd.set_tgt) begin
            r_tgt <= n_tgt;
        end
        if (i_cmd.out_load) begin
            r_ostatus <= i_cmd.out_elem ? ST_DONE : i_cmd.out_status;
            r_oelem   <= i_cmd.out_elem ? r_rdata : '0;
            r_oevalid <= i_cmd.out_elem;
            r_olast   <= i_cmd.out_elem ? (idx_next == r_len) : 1'b1;
            r_olen    <= LEN_OUT_W'(r_len);
        end
    end

    always_comb begin
        o_sts.mode     = r_mode;
        o_sts.full     = (r_len == LW'(CAPACITY));
        o_sts.pos_bad  = ((POS_W + 1)'(r_pos) > (POS_W + 1)'(r_len));
        o_sts.len_zero = (r_len == '0);
        o_sts.at_tgt   = (r_idx == r_tgt);
        o_sts.match    = (r_rdata == r_value);
        o_sts.idx_last = (idx_next == r_len);
        o_sts.out_free = !r_ovalid || i_ready;
    end

    assign o_valid         = r_ovalid;
    assign o_status        = r_ostatus;
    assign o_element       = r_oelem;
    assign o_element_valid = r_oevalid;
    assign o_last          = r_olast;
    assign o_list_length   = r_olen;

endmodule

[design/bounded_ordered_list_engine.sv]
// Bounded ordered list of up to CAPACITY signed 32-bit values held in a
// single-port-read entry memory. One operation is taken at a time; the input
// is ready again once the operation's last result is in the output register,
// so a new operation can start while that result waits to be taken. Every
// memory step goes through the one registered read port: each moved or
// visited entry takes a read state and then a compare, write or output state,
// so insert time grows with length minus index, remove and dump time with
// the length. Entries are not cleared after reset.
// ----------------------------------------------------------------------------
// bounded_ordered_list_engine
// Top level: joins the operation sequencer and the list datapath to the
// operation and result channels.
// ----------------------------------------------------------------------------
module bounded_ordered_list_engine import bole_pkg::*; #(
    parameter int CAPACITY = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bole_in_if.sink     i_in,
    bole_out_if.source  o_out
);

    t_cmd cmd;
    t_sts sts;

    bole_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (i_in.ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    bole_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_mode          (i_in.mode),
        .i_value         (i_in.value),
        .i_position      (i_in.position),
        .o_valid         (o_out.valid),
        .i_ready         (o_out.ready),
        .o_status        (o_out.status),
        .o_element       (o_out.element),
        .o_element_valid (o_out.element_valid),
        .o_last          (o_out.last),
        .o_list_length   (o_out.list_length)
    );

    // one operation in flight: no second transfer right after the first
    a_one_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> !i_in.ready)
        else $error("input taken while an operation is in progress");

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("result register loaded while still full");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.list_length <= LEN_OUT_W'(CAPACITY))
        else $error("list length above capacity");

    // memory is only written inside an operation
    a_wr_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.wr_en |-> !i_in.ready)
        else $error("entry write while idle");

endmodule
